### sv/mtq_pkg.sv
// ----------------------------------------------------------------------------
// mtq_pkg
// shared widths, result codes and the slot command word of the timer queue
// ----------------------------------------------------------------------------
`default_nettype none

package mtq_pkg;

  localparam int unsigned TIMER_SLOTS_DEF = 16;
  localparam int unsigned MAX_SLOTS       = 16;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned PERIOD_W        = 32;
  localparam int unsigned HANDLE_W        = 4;
  localparam int unsigned KIND_W          = 3;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_STARTED       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START_REFUSED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOPPED       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP_REFUSED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED       = 3'd4;

  typedef struct packed {
    logic claim;     // load period into the addressed slot and mark it active
    logic periodic;  // mode taken with claim
    logic free;      // cancel the addressed slot
    logic count;     // one millisecond step on the addressed slot
  } slot_cmd_t;

endpackage

`default_nettype wire

### sv/multi_timer_queue.sv
// ----------------------------------------------------------------------------
// multi_timer_queue
// millisecond timers in fixed slots: start, stop and tick words swept over
// the slots by a small sequencer sharing one countdown unit
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                    | tuser   | tlast
//  s_      | in  | fire_once[0] period_ms[32:1] handle[36:33] | op[1:0] | -
//  m_      | out | slot[3:0]                                | kind    | last
//
//  start: accept, then a step per slot up to and including the first free
//  one (every usable slot when all are taken); stop: accept plus one step;
//  tick: accept plus a step per usable slot plus a closing flush step.
//  the scan holds wherever a result must go out while the output register
//  is still full. synchronous reset frees every slot at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_queue #(
  parameter int unsigned TIMER_SLOTS = mtq_pkg::TIMER_SLOTS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // fire_once, period_ms, handle, zero fill
  input  wire  [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // slot, zero fill
  output logic [2:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);

  localparam int unsigned USABLE = (TIMER_SLOTS < mtq_pkg::MAX_SLOTS) ?
                                   TIMER_SLOTS : mtq_pkg::MAX_SLOTS;
  localparam int unsigned IW     = $clog2(USABLE);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_STOP  = 3'd2;
  localparam logic [2:0] ST_TICK  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]                       state;
  logic [2:0]                       state_next;
  logic [IW-1:0]                    cnt;
  logic                             fire_once;
  logic [mtq_pkg::PERIOD_W-1:0]     period_ms;
  logic [mtq_pkg::HANDLE_W-1:0]     handle;
  logic                             pend_valid;
  logic [IW-1:0]                    pend_slot;
  logic                             out_valid;
  logic [mtq_pkg::KIND_W-1:0]       out_kind;
  logic [mtq_pkg::HANDLE_W-1:0]     out_slot;
  logic                             out_last;

  mtq_pkg::slot_cmd_t               cmd;
  logic [IW-1:0]                    idx;
  logic                             slot_active;
  logic                             slot_expiring;
  logic                             out_free;
  logic                             in_range;
  logic                             last_slot;
  logic                             emit;
  logic [mtq_pkg::KIND_W-1:0]       e_kind;
  logic [mtq_pkg::HANDLE_W-1:0]     e_slot;
  logic                             e_last;
  logic                             advance;
  logic                             pend_load;
  logic                             pend_clear;

  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !out_valid || m_tready;
  assign in_range  = {1'b0, handle} < (mtq_pkg::HANDLE_W + 1)'(USABLE);
  assign last_slot = (cnt == IW'(USABLE - 1));
  assign idx       = (state == ST_STOP) ? handle[IW-1:0] : cnt;

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_slot};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  mtq_slots #(
    .SLOTS (USABLE)
  ) u_slots (
    .clk           (clk),
    .rst           (rst),
    .idx           (idx),
    .cmd           (cmd),
    .period        (period_ms),
    .slot_active   (slot_active),
    .slot_expiring (slot_expiring)
  );

  always_comb begin
    cmd        = '0;
    emit       = 1'b0;
    e_kind     = mtq_pkg::KIND_STARTED;
    e_slot     = '0;
    e_last     = 1'b1;
    advance    = 1'b0;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        pend_clear = 1'b1;
        if (s_tvalid) begin
          unique case (s_tuser)
            mtq_pkg::OP_TICK:  state_next = ST_TICK;
            mtq_pkg::OP_START: state_next = ST_START;
            mtq_pkg::OP_STOP:  state_next = ST_STOP;
            default:           state_next = ST_IDLE;
          endcase
        end
      end
      ST_START: begin
        if (!slot_active) begin
          if (out_free) begin
            cmd.claim    = 1'b1;
            cmd.periodic = !fire_once;
            emit         = 1'b1;
            e_kind       = mtq_pkg::KIND_STARTED;
            e_slot       = mtq_pkg::HANDLE_W'(cnt);
            state_next   = ST_IDLE;
          end
        end else if (last_slot) begin
          if (out_free) begin
            emit       = 1'b1;
            e_kind     = mtq_pkg::KIND_START_REFUSED;
            state_next = ST_IDLE;
          end
        end else begin
          advance = 1'b1;
        end
      end
      ST_STOP: begin
        if (out_free) begin
          emit       = 1'b1;
          e_slot     = handle;
          state_next = ST_IDLE;
          if (in_range && slot_active) begin
            cmd.free = 1'b1;
            e_kind   = mtq_pkg::KIND_STOPPED;
          end else begin
            e_kind   = mtq_pkg::KIND_STOP_REFUSED;
          end
        end
      end
      ST_TICK: begin
        if (slot_active && slot_expiring && pend_valid) begin
          if (out_free) begin
            emit    = 1'b1;
            e_kind  = mtq_pkg::KIND_EXPIRED;
            e_slot  = mtq_pkg::HANDLE_W'(pend_slot);
            e_last  = 1'b0;
            advance = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
        if (advance) begin
          cmd.count = slot_active;
          pend_load = slot_active && slot_expiring;
          if (last_slot) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          emit       = 1'b1;
          e_kind     = mtq_pkg::KIND_EXPIRED;
          e_slot     = mtq_pkg::HANDLE_W'(pend_slot);
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (pend_clear) begin
        pend_valid <= 1'b0;
      end else if (pend_load) begin
        pend_valid <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cnt <= '0;
    end else if (advance && !last_slot) begin
      cnt <= cnt + IW'(1);
    end
    if (s_tvalid && s_tready) begin
      fire_once <= s_tdata[0];
      period_ms <= s_tdata[32:1];
      handle    <= s_tdata[36:33];
    end
    if (pend_load) begin
      pend_slot <= cnt;
    end
    if (emit) begin
      out_kind <= e_kind;
      out_slot <= e_slot;
      out_last <= e_last;
    end
  end

endmodule

`default_nettype wire

### sv/mtq_slots.sv
// ----------------------------------------------------------------------------
// mtq_slots
// slot store with the shared countdown unit: one slot read, compared and
// stepped per cycle at the index given by the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module mtq_slots #(
  parameter int unsigned SLOTS = mtq_pkg::TIMER_SLOTS_DEF,
  localparam int unsigned IW   = $clog2(SLOTS)
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  [IW-1:0]                    idx,
  input  mtq_pkg::slot_cmd_t               cmd,
  input  wire  [mtq_pkg::PERIOD_W-1:0]     period,
  output logic                             slot_active,
  output logic                             slot_expiring
);

  logic [SLOTS-1:0]                 active_bits;
  logic [SLOTS-1:0]                 periodic_bits;
  logic [mtq_pkg::PERIOD_W-1:0]     remaining [SLOTS];
  logic [mtq_pkg::PERIOD_W-1:0]     reload    [SLOTS];
  logic [mtq_pkg::PERIOD_W-1:0]     cur;
  logic [mtq_pkg::PERIOD_W-1:0]     dec;

  assign cur           = remaining[idx];
  assign dec           = cur - mtq_pkg::PERIOD_W'(1);
  assign slot_expiring = ~|cur[mtq_pkg::PERIOD_W-1:1];
  assign slot_active   = active_bits[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits   <= '0;
      periodic_bits <= '0;
    end else begin
      if (cmd.claim) begin
        active_bits[idx]   <= 1'b1;
        periodic_bits[idx] <= cmd.periodic;
      end
      if (cmd.free) begin
        active_bits[idx]   <= 1'b0;
        periodic_bits[idx] <= 1'b0;
      end
      if (cmd.count && slot_expiring && !periodic_bits[idx]) begin
        active_bits[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.claim) begin
      remaining[idx] <= period;
      reload[idx]    <= period;
    end else if (cmd.count) begin
      remaining[idx] <= slot_expiring ? reload[idx] : dec;
    end
  end

endmodule

`default_nettype wire

### tb/sv/multi_timer_queue_tb.sv
// ----------------------------------------------------------------------------
// multi_timer_queue_tb
// self-checking bench for the slot timer queue: start, stop and tick words go
// in over the slave stream, a local model of the slots forecasts every
// started, refused, stopped and expired word, and the master stream is
// checked against it in order while both sides idle at random in phases
// ----------------------------------------------------------------------------

module multi_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS  = mtq_pkg::TIMER_SLOTS_DEF;
  localparam int unsigned USABLE = (SLOTS < 16) ? SLOTS : 16;
  localparam logic [mtq_pkg::OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [mtq_pkg::OP_W-1:0]     op;
    logic                         fire_once;
    logic [mtq_pkg::PERIOD_W-1:0] period_ms;
    logic [mtq_pkg::HANDLE_W-1:0] handle;
  } timer_word_t;

  typedef struct packed {
    logic [mtq_pkg::KIND_W-1:0]   kind;
    logic [mtq_pkg::HANDLE_W-1:0] slot;
    logic                         last;
  } timer_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  timer_word_t  pending_words[$];
  timer_event_t expected_events[$];
  int unsigned  words_queued   = 0;
  int unsigned  words_accepted = 0;
  int unsigned  error_count    = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;

  // slot model
  logic                         timer_on     [USABLE];
  logic                         timer_repeat [USABLE];
  logic [mtq_pkg::PERIOD_W-1:0] timer_left   [USABLE];
  logic [mtq_pkg::PERIOD_W-1:0] timer_period [USABLE];

  multi_timer_queue #(
    .TIMER_SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < USABLE; s++) begin
      timer_on[s]     = 1'b0;
      timer_repeat[s] = 1'b0;
      timer_left[s]   = '0;
      timer_period[s] = '0;
    end
  end

  function automatic void forecast_timer_events(input timer_word_t w);
    timer_event_t ev;
    timer_event_t fired[$];
    int           free_slot;
    free_slot = -1;
    case (w.op)
      mtq_pkg::OP_START: begin
        for (int s = USABLE - 1; s >= 0; s--) begin
          if (!timer_on[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          ev = '{kind: mtq_pkg::KIND_START_REFUSED, slot: '0, last: 1'b1};
        end else begin
          timer_on[free_slot]     = 1'b1;
          timer_repeat[free_slot] = !w.fire_once;
          timer_left[free_slot]   = w.period_ms;
          timer_period[free_slot] = w.period_ms;
          ev = '{kind: mtq_pkg::KIND_STARTED,
                 slot: free_slot[mtq_pkg::HANDLE_W-1:0], last: 1'b1};
        end
        expected_events.push_back(ev);
      end
      mtq_pkg::OP_STOP: begin
        if (w.handle < USABLE && timer_on[w.handle]) begin
          timer_on[w.handle]     = 1'b0;
          timer_repeat[w.handle] = 1'b0;
          ev = '{kind: mtq_pkg::KIND_STOPPED, slot: w.handle, last: 1'b1};
        end else begin
          ev = '{kind: mtq_pkg::KIND_STOP_REFUSED, slot: w.handle, last: 1'b1};
        end
        expected_events.push_back(ev);
      end
      mtq_pkg::OP_TICK: begin
        for (int s = 0; s < USABLE; s++) begin
          if (timer_on[s]) begin
            if (timer_left[s] <= 1) begin
              fired.push_back('{kind: mtq_pkg::KIND_EXPIRED,
                                slot: s[mtq_pkg::HANDLE_W-1:0], last: 1'b0});
              if (timer_repeat[s]) timer_left[s] = timer_period[s];
              else timer_on[s] = 1'b0;
            end else begin
              timer_left[s] = timer_left[s] - 1;
            end
          end
        end
        if (fired.size() > 0) fired[fired.size() - 1].last = 1'b1;
        foreach (fired[i]) expected_events.push_back(fired[i]);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic queue_word(input logic [mtq_pkg::OP_W-1:0] op, input logic fire_once,
                            input logic [mtq_pkg::PERIOD_W-1:0] period_ms,
                            input logic [mtq_pkg::HANDLE_W-1:0] handle);
    pending_words.push_back('{op: op, fire_once: fire_once, period_ms: period_ms,
                              handle: handle});
    words_queued++;
  endtask

  // driver
  always @(posedge clk) begin
    timer_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, w.handle, w.period_ms, w.fire_once};
        s_tuser  <= w.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    timer_event_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        forecast_timer_events('{op: s_tuser, fire_once: s_tdata[0],
                                period_ms: s_tdata[32:1], handle: s_tdata[36:33]});
        words_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_events.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("multi_timer_queue_tb: unexpected word kind %0d slot %0d last %0d",
                     m_tuser, m_tdata[3:0], m_tlast);
        end else begin
          want = expected_events.pop_front();
          if (m_tuser !== want.kind || m_tdata[3:0] !== want.slot ||
              m_tlast !== want.last) begin
            error_count++;
            if (error_count <= 10)
              $display({"multi_timer_queue_tb: mismatch, expected kind %0d slot %0d ",
                        "last %0d, got kind %0d slot %0d last %0d"},
                       want.kind, want.slot, want.last, m_tuser, m_tdata[3:0], m_tlast);
          end
        end
      end
    end
  end

  initial begin
    int unsigned useful;
    int unsigned pick;
    int unsigned period_pick;
    timer_word_t w;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase

      if (phase == 0) begin
        // quiet tick, period zero, period one, periodic zero, longest period
        queue_word(mtq_pkg::OP_TICK,  1'b0, 32'd0,         4'd0);
        queue_word(mtq_pkg::OP_START, 1'b1, 32'd0,         4'd0);
        queue_word(mtq_pkg::OP_START, 1'b0, 32'd1,         4'd0);
        queue_word(mtq_pkg::OP_START, 1'b0, 32'd0,         4'd0);
        queue_word(mtq_pkg::OP_START, 1'b1, 32'hFFFF_FFFF, 4'd0);
        queue_word(mtq_pkg::OP_TICK,  1'b1, 32'hFFFF_FFFF, 4'hF);
        queue_word(mtq_pkg::OP_STOP,  1'b1, 32'hFFFF_FFFF, 4'd2);
        queue_word(mtq_pkg::OP_STOP,  1'b0, 32'd0,         4'd3);
        queue_word(mtq_pkg::OP_STOP,  1'b0, 32'd0,         4'hF);
        queue_word(OP_SPARE,          1'b1, 32'hFFFF_FFFF, 4'hF);
        // fill every slot, one more is refused, then all expire at once
        for (int i = 0; i < USABLE; i++)
          queue_word(mtq_pkg::OP_START, 1'b1, i[0] ? 32'd1 : 32'd0, 4'hF);
        queue_word(mtq_pkg::OP_TICK, 1'b0, 32'd0, 4'd0);
      end

      useful = 0;
      while (useful < 84) begin
        pick = $urandom_range(99);
        w.fire_once = 1'($urandom_range(1));
        w.period_ms = $urandom;
        w.handle    = mtq_pkg::HANDLE_W'($urandom_range(15));
        if (pick < 40) begin
          w.op = mtq_pkg::OP_TICK;
        end else if (pick < 70) begin
          w.op = mtq_pkg::OP_START;
          period_pick = $urandom_range(99);
          if (period_pick < 70) w.period_ms = $urandom_range(6);
          else if (period_pick < 85) w.period_ms = $urandom_range(40, 7);
          else if (period_pick >= 95) w.period_ms = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1;
        end else if (pick < 95) begin
          w.op = mtq_pkg::OP_STOP;
        end else begin
          w.op = OP_SPARE;
        end
        queue_word(w.op, w.fire_once, w.period_ms, w.handle);
        if (w.op != OP_SPARE) useful++;
      end

      // hold the sender until the queue has drained completely
      while (words_accepted != words_queued) @(posedge clk);
      while (expected_events.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    error_count += expected_events.size();
    if (error_count == 0) begin
      $display("multi_timer_queue_tb: done, clean");
    end else begin
      $display("multi_timer_queue_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("multi_timer_queue_tb: done, errors");
    $finish;
  end

endmodule
